### design/number_literal_recognizer_assert.svh
// Assertion macros for the number literal recognizer.
// Included by the top-level RTL file, which carries the concurrent assertions; no other dependencies.
`ifndef NUMBER_LITERAL_RECOGNIZER_ASSERT_SVH
`define NUMBER_LITERAL_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NLR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("number literal recognizer: assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("number literal recognizer: assertion failed");

`endif

### design/nlr_pkg.sv
// Package for the number literal recognizer: word types, scan phase codes,
// character constants and character class functions. No dependencies.
package nlr_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_scan;
		logic       number_expected;
	} in_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] token_length;
		logic [7:0] skipped_count;
	} out_t;

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
	localparam logic [PHASE_W-1:0] PH_WS    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ZERO  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_HEX   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_INT   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_DOT   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_FRAC  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ESIGN = 4'd7;
	localparam logic [PHASE_W-1:0] PH_EDIG  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_BD    = 4'd9;

	// Counters are widened to this before clipping to the 8-bit result fields.
	localparam int LEN_EXT_W = 16;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_D   = 8'h64;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_L   = 8'h6C;
	localparam logic [7:0] CH_LO_S   = 8'h73;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) ||
			(c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | 8'h20) : c;
	endfunction

endpackage

### design/nlr_core.sv
// Scan state and one-character transition of the number literal recognizer.
// Depends on nlr_pkg.
module nlr_core #(
	parameter int LENGTH_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  nlr_pkg::in_t  item,
	output logic          res_valid,
	output nlr_pkg::out_t res
);
	import nlr_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LenMax = '1;

	logic [PHASE_W-1:0]     phase_q, n_phase;
	logic [LENGTH_BITS-1:0] cons_q, n_cons;
	logic [LENGTH_BITS-1:0] mark_q, n_mark;
	logic [LENGTH_BITS-1:0] ws_q, n_ws;
	logic                   hex_q, n_hex;

	function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
		return (v == LenMax) ? v : v + 1'b1;
	endfunction

	function automatic logic [7:0] clip8(input logic [LENGTH_BITS-1:0] v);
		logic [LEN_EXT_W-1:0] e;
		e = LEN_EXT_W'(v);
		return (e > LEN_EXT_W'(255)) ? 8'hFF : e[7:0];
	endfunction

	logic [7:0]             c, lc;
	logic                   int_step, frac_step, edig_step, do_exp, do_suffix;
	logic                   fin_ok;
	logic [LENGTH_BITS-1:0] fin_len;

	always_comb begin
		c         = item.ch;
		lc        = to_lower(item.ch);
		n_phase   = phase_q;
		n_cons    = cons_q;
		n_mark    = mark_q;
		n_ws      = ws_q;
		n_hex     = hex_q;
		res_valid = 1'b0;
		fin_ok    = 1'b0;
		fin_len   = '0;
		int_step  = 1'b0;
		frac_step = 1'b0;
		edig_step = 1'b0;
		do_exp    = 1'b0;
		do_suffix = 1'b0;

		if (item.start_scan) begin
			n_cons  = '0;
			n_mark  = '0;
			n_ws    = '0;
			n_hex   = 1'b0;
			n_phase = PH_WS;
			if (!item.number_expected) begin
				res_valid = 1'b1;
			end
		end

		if (!res_valid) begin
			unique case (n_phase)
				PH_WS: begin
					if (is_space(c)) begin
						n_ws = sat_inc(n_ws);
					end else if (!is_digit(c)) begin
						res_valid = 1'b1;
					end else begin
						n_cons  = sat_inc(n_cons);
						n_phase = (c == CH_ZERO) ? PH_ZERO : PH_INT;
					end
				end
				PH_ZERO: begin
					if (lc == CH_X) begin
						n_cons  = sat_inc(n_cons);
						n_phase = PH_HEX;
					end else begin
						n_phase  = PH_INT;
						int_step = 1'b1;
					end
				end
				PH_HEX: begin
					if (is_xdigit(c)) begin
						n_cons = sat_inc(n_cons);
						n_hex  = 1'b1;
					end else if (!n_hex) begin
						res_valid = 1'b1;
					end else begin
						res_valid = 1'b1;
						fin_ok    = 1'b1;
						fin_len   = (lc == CH_LO_L || lc == CH_LO_S) ? sat_inc(n_cons) : n_cons;
					end
				end
				PH_INT: int_step = 1'b1;
				PH_DOT: begin
					if (c == CH_DOT || is_alpha(c) || c == CH_UNDER || c == CH_DOLLAR) begin
						res_valid = 1'b1;
						fin_ok    = 1'b1;
						fin_len   = n_mark;
					end else begin
						n_phase   = PH_FRAC;
						frac_step = 1'b1;
					end
				end
				PH_FRAC: frac_step = 1'b1;
				PH_ESIGN: begin
					n_phase = PH_EDIG;
					if (c == CH_PLUS || c == CH_MINUS) begin
						n_cons = sat_inc(n_cons);
					end else begin
						edig_step = 1'b1;
					end
				end
				PH_EDIG: edig_step = 1'b1;
				PH_BD: begin
					res_valid = 1'b1;
					fin_ok    = 1'b1;
					fin_len   = (lc == CH_LO_D) ? sat_inc(n_cons) : n_cons;
				end
				default: n_phase = PH_IDLE;
			endcase
		end

		if (int_step) begin
			if (is_digit(c)) begin
				n_cons = sat_inc(n_cons);
			end else if (c == CH_DOT) begin
				n_mark  = n_cons;
				n_cons  = sat_inc(n_cons);
				n_phase = PH_DOT;
			end else begin
				do_exp = 1'b1;
			end
		end
		if (frac_step) begin
			if (is_digit(c)) begin
				n_cons = sat_inc(n_cons);
			end else begin
				do_exp = 1'b1;
			end
		end
		if (edig_step) begin
			if (is_digit(c)) begin
				n_cons = sat_inc(n_cons);
			end else begin
				do_suffix = 1'b1;
			end
		end
		if (do_exp) begin
			if (lc == CH_LO_E) begin
				n_cons  = sat_inc(n_cons);
				n_phase = PH_ESIGN;
			end else begin
				do_suffix = 1'b1;
			end
		end
		if (do_suffix) begin
			if (lc == CH_LO_B) begin
				n_cons  = sat_inc(n_cons);
				n_phase = PH_BD;
			end else begin
				res_valid = 1'b1;
				fin_ok    = 1'b1;
				fin_len   = (lc == CH_LO_F || lc == CH_LO_D || lc == CH_LO_L || lc == CH_LO_S) ?
					sat_inc(n_cons) : n_cons;
			end
		end

		if (res_valid) begin
			n_phase = PH_IDLE;
		end

		res.accepted      = fin_ok;
		res.token_length  = fin_ok ? clip8(fin_len) : 8'd0;
		res.skipped_count = clip8(n_ws);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cons_q  <= '0;
			mark_q  <= '0;
			ws_q    <= '0;
			hex_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= n_phase;
			cons_q  <= n_cons;
			mark_q  <= n_mark;
			ws_q    <= n_ws;
			hex_q   <= n_hex;
		end
	end

endmodule

### design/number_literal_recognizer.sv
// Top level of the number literal recognizer: input register, scan core, result register.
// Depends on nlr_pkg, nlr_core and number_literal_recognizer_assert.svh.
//
//   channel  handshake             word
//   in       in_valid / in_ready   in_data  (nlr_pkg::in_t: ch, start_scan, number_expected)
//   out      out_valid / out_ready out_data (nlr_pkg::out_t: accepted, token_length,
//                                            skipped_count)
//
// One character is taken per cycle unless a stall holds it. A character that is accepted
// sits in the input register, and the scan core steps on it once the result register can
// take its result; a result word that it decides is then loaded there and becomes valid.
// Reset clears the scan state to idle and empties both registers.
// A full result register stalls only a character that decides a scan; other characters
// keep flowing while a result waits.
`include "number_literal_recognizer_assert.svh"

module number_literal_recognizer #(
	parameter int LENGTH_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nlr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output nlr_pkg::out_t out_data
);
	import nlr_pkg::*;

	logic  valid_s1;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  res_valid;
	out_t  res;
	logic  fire;

	assign fire     = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	nlr_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (fire),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`NLR_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && res_valid && out_valid_q && !out_ready)
	`NLR_ASSERT_NEXT(a_result_loaded, clk, arst_n, fire && res_valid, out_valid_q)
	`NLR_ASSERT_IMP(a_reject_no_length, clk, arst_n, out_valid_q && !out_q.accepted, out_q.token_length == 8'd0)
	`NLR_ASSERT_IMP(a_result_clean_start, clk, arst_n, valid_s1 && item_s1.start_scan && !item_s1.number_expected, res_valid && !res.accepted && res.skipped_count == 8'd0)

endmodule
